// ===== hdl/pra_pkg.sv =====
// ----------------------------------------------------------------------------
// Page run allocator package
// Shared widths, codes, request structs and the size-order function.
// ----------------------------------------------------------------------------
package pra_pkg;

  localparam int WINDOW_PAGES = 4096;
  localparam int SIZE_ORDERS  = 16;
  localparam int IDX_W        = $clog2(WINDOW_PAGES);
  localparam int TAG_W        = $clog2(WINDOW_PAGES + 1);
  localparam int ORD_W        = $clog2(SIZE_ORDERS);
  localparam int ALU_W        = TAG_W + 1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [ORD_W-1:0] ord_t;
  typedef logic [ALU_W-1:0] alu_word_t;

  // A link value of WINDOW_PAGES marks the end of a list.
  localparam tag_t NULL_LINK = tag_t'(WINDOW_PAGES);

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_BADCNT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD   = 2'd0,
    ALU_SUB   = 2'd1,
    ALU_ADDM1 = 2'd2
  } alu_op_t;

  typedef struct packed {
    alu_op_t   op;
    alu_word_t a;
    alu_word_t b;
  } alu_req_t;

  typedef struct packed {
    alu_word_t res;
    logic      ge;
  } alu_rsp_t;

  typedef struct packed {
    logic we;
    idx_t addr;
    tag_t data;
  } word_wr_t;

  typedef struct packed {
    logic we;
    idx_t addr;
    logic data;
  } bit_wr_t;

  typedef struct packed {
    idx_t     raddr;
    word_wr_t tag_wr;
    bit_wr_t  free_wr;
    word_wr_t next_wr;
    word_wr_t prev_wr;
  } store_req_t;

  typedef struct packed {
    tag_t tag;
    logic free;
    tag_t nxt;
    tag_t prv;
  } store_rsp_t;

  // Order of a run length: floor(log2(len)), capped at the top order.
  function automatic ord_t size_order(tag_t len);
    int o;
    o = 0;
    for (int i = 1; i < TAG_W; i++) begin
      if (len[i]) o = i;
    end
    if (o > SIZE_ORDERS - 1) o = SIZE_ORDERS - 1;
    return ORD_W'(o);
  endfunction

endpackage

// ===== hdl/pra_alu.sv =====
// ----------------------------------------------------------------------------
// Page run allocator arithmetic unit
// One adder/subtractor with a compare flag, shared by the sequencer steps.
// ----------------------------------------------------------------------------
module pra_alu (
  input  pra_pkg::alu_req_t req,
  output pra_pkg::alu_rsp_t rsp
);

  always_comb begin
    case (req.op)
      pra_pkg::ALU_ADD:   rsp.res = req.a + req.b;
      pra_pkg::ALU_SUB:   rsp.res = req.a - req.b;
      pra_pkg::ALU_ADDM1: rsp.res = req.a + req.b - 1'b1;
      default:            rsp.res = req.a;
    endcase
    rsp.ge = (req.a >= req.b);
  end

endmodule

// ===== hdl/pra_store.sv =====
// ----------------------------------------------------------------------------
// Page run allocator page store
// Boundary tags, free marks, list links: one write each, one read per cycle.
// ----------------------------------------------------------------------------
module pra_store (
  input  logic                clk,
  input  pra_pkg::store_req_t req,
  output pra_pkg::store_rsp_t rsp
);

  pra_pkg::tag_t tag_mem  [pra_pkg::WINDOW_PAGES];
  logic          free_mem [pra_pkg::WINDOW_PAGES];
  pra_pkg::tag_t next_mem [pra_pkg::WINDOW_PAGES];
  pra_pkg::tag_t prev_mem [pra_pkg::WINDOW_PAGES];

  always_ff @(posedge clk) begin
    if (req.tag_wr.we) tag_mem[req.tag_wr.addr] <= req.tag_wr.data;
    rsp.tag <= tag_mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (req.free_wr.we) free_mem[req.free_wr.addr] <= req.free_wr.data;
    rsp.free <= free_mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (req.next_wr.we) next_mem[req.next_wr.addr] <= req.next_wr.data;
    rsp.nxt <= next_mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (req.prev_wr.we) prev_mem[req.prev_wr.addr] <= req.prev_wr.data;
    rsp.prv <= prev_mem[req.raddr];
  end

endmodule

// ===== hdl/pra_seq.sv =====
// ----------------------------------------------------------------------------
// Page run allocator sequencer
// Walks the free lists, unlinks, merges and pushes runs one step a cycle.
// ----------------------------------------------------------------------------
module pra_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                operation,
  input  logic [12:0]         page_count,
  input  logic [11:0]         run_start,
  output logic                busy,
  output logic                done,
  output logic [1:0]          status,
  output logic [11:0]         granted_start,
  output pra_pkg::alu_req_t   alu_req,
  input  pra_pkg::alu_rsp_t   alu_rsp,
  output pra_pkg::store_req_t st_req,
  input  pra_pkg::store_rsp_t st_rsp
);

  localparam int IW = pra_pkg::IDX_W;
  localparam int TW = pra_pkg::TAG_W;
  localparam int AW = pra_pkg::ALU_W;
  localparam int W  = pra_pkg::WINDOW_PAGES;
  localparam int NO = pra_pkg::SIZE_ORDERS;

  typedef enum logic [28:0] {
    S_CLR   = 29'd1 << 0,
    S_INIT0 = 29'd1 << 1,
    S_INIT1 = 29'd1 << 2,
    S_IDLE  = 29'd1 << 3,
    S_A1    = 29'd1 << 4,
    S_A2    = 29'd1 << 5,
    S_ANEXT = 29'd1 << 6,
    S_AX0   = 29'd1 << 7,
    S_AX1   = 29'd1 << 8,
    S_AX2   = 29'd1 << 9,
    S_AX3   = 29'd1 << 10,
    S_FR1   = 29'd1 << 11,
    S_L0    = 29'd1 << 12,
    S_L1    = 29'd1 << 13,
    S_L1B   = 29'd1 << 14,
    S_L2    = 29'd1 << 15,
    S_L3    = 29'd1 << 16,
    S_R0    = 29'd1 << 17,
    S_R1    = 29'd1 << 18,
    S_R2    = 29'd1 << 19,
    S_F0    = 29'd1 << 20,
    S_F1    = 29'd1 << 21,
    S_F2    = 29'd1 << 22,
    S_F3    = 29'd1 << 23,
    S_RM0   = 29'd1 << 24,
    S_RM1   = 29'd1 << 25,
    S_RM2   = 29'd1 << 26,
    S_DONE  = 29'd1 << 27,
    S_SPARE = 29'd1 << 28
  } state_t;

  state_t            state, ret;
  pra_pkg::tag_t     heads [NO];
  pra_pkg::tag_t     clr;
  pra_pkg::tag_t     cnt, steps, have, rem, len, t, tn, rlen, old;
  pra_pkg::ord_t     o;
  pra_pkg::idx_t     p, found, last, sp, pp, n, rp, granted;
  pra_pkg::status_t  st;
  pra_pkg::ord_t     push_ord, rm_ord;

  assign push_ord      = pra_pkg::size_order(len);
  assign rm_ord        = pra_pkg::size_order(rlen);
  assign busy          = (state != S_IDLE);
  assign done          = (state == S_DONE);
  assign status        = st;
  assign granted_start = granted;

  always_comb begin
    alu_req        = '0;
    alu_req.op     = pra_pkg::ALU_ADD;
    st_req         = '0;
    st_req.raddr   = p;
    case (state)
      S_CLR: begin
        st_req.tag_wr  = '{we: 1'b1, addr: clr[IW-1:0], data: '0};
        st_req.free_wr = '{we: 1'b1, addr: clr[IW-1:0], data: 1'b0};
        st_req.next_wr = '{we: 1'b1, addr: clr[IW-1:0], data: pra_pkg::NULL_LINK};
        st_req.prev_wr = '{we: 1'b1, addr: clr[IW-1:0], data: pra_pkg::NULL_LINK};
      end
      S_INIT0: begin
        st_req.tag_wr  = '{we: 1'b1, addr: '0, data: TW'(W)};
        st_req.free_wr = '{we: 1'b1, addr: '0, data: 1'b1};
      end
      S_INIT1: st_req.tag_wr = '{we: 1'b1, addr: IW'(W - 1), data: TW'(W)};
      S_IDLE:  st_req.raddr = run_start;
      S_A1:    st_req.raddr = heads[o][IW-1:0];
      S_A2: begin
        alu_req.op   = pra_pkg::ALU_SUB;
        alu_req.a    = AW'(st_rsp.tag);
        alu_req.b    = AW'(cnt);
        st_req.raddr = st_rsp.nxt[IW-1:0];
      end
      S_FR1: begin
        alu_req.a = AW'(sp);
        alu_req.b = AW'(st_rsp.tag);
      end
      S_RM0: st_req.raddr = rp;
      S_RM1: begin
        if (st_rsp.prv < pra_pkg::NULL_LINK)
          st_req.next_wr = '{we: 1'b1, addr: st_rsp.prv[IW-1:0], data: st_rsp.nxt};
        if (st_rsp.nxt < pra_pkg::NULL_LINK)
          st_req.prev_wr = '{we: 1'b1, addr: st_rsp.nxt[IW-1:0], data: st_rsp.prv};
      end
      S_RM2: begin
        st_req.next_wr = '{we: 1'b1, addr: rp, data: pra_pkg::NULL_LINK};
        st_req.prev_wr = '{we: 1'b1, addr: rp, data: pra_pkg::NULL_LINK};
        st_req.free_wr = '{we: 1'b1, addr: rp, data: 1'b0};
      end
      S_AX0: begin
        st_req.tag_wr = '{we: 1'b1, addr: found, data: cnt};
        alu_req.op    = pra_pkg::ALU_ADDM1;
        alu_req.a     = AW'(found);
        alu_req.b     = AW'(cnt);
      end
      S_AX1: begin
        st_req.tag_wr = '{we: 1'b1, addr: last, data: cnt};
        alu_req.op    = pra_pkg::ALU_SUB;
        alu_req.a     = AW'(have);
        alu_req.b     = AW'(cnt);
      end
      S_AX2: begin
        alu_req.a = AW'(found);
        alu_req.b = AW'(have);
      end
      S_AX3: begin
        alu_req.a = AW'(found);
        alu_req.b = AW'(cnt);
      end
      S_L0: begin
        alu_req.op   = pra_pkg::ALU_SUB;
        alu_req.a    = AW'(sp);
        alu_req.b    = AW'(1);
        st_req.raddr = alu_rsp.res[IW-1:0];
      end
      S_L1: begin
        alu_req.op = pra_pkg::ALU_SUB;
        alu_req.a  = AW'(sp);
        alu_req.b  = AW'(st_rsp.tag);
      end
      S_L1B: begin
        alu_req.op   = pra_pkg::ALU_SUB;
        alu_req.a    = AW'(sp);
        alu_req.b    = AW'(t);
        st_req.raddr = alu_rsp.res[IW-1:0];
      end
      S_L3: begin
        alu_req.a = AW'(len);
        alu_req.b = AW'(t);
      end
      S_R0: begin
        alu_req.a    = AW'(sp);
        alu_req.b    = AW'(len);
        st_req.raddr = alu_rsp.res[IW-1:0];
      end
      S_R1: begin
        alu_req.a = AW'(n);
        alu_req.b = AW'(st_rsp.tag);
      end
      S_R2: begin
        alu_req.a = AW'(len);
        alu_req.b = AW'(tn);
      end
      S_F0: st_req.tag_wr = '{we: 1'b1, addr: sp, data: len};
      S_F1: begin
        alu_req.op    = pra_pkg::ALU_ADDM1;
        alu_req.a     = AW'(sp);
        alu_req.b     = AW'(len);
        st_req.tag_wr = '{we: 1'b1, addr: alu_rsp.res[IW-1:0], data: len};
      end
      S_F2: begin
        st_req.next_wr = '{we: 1'b1, addr: sp, data: heads[push_ord]};
        st_req.prev_wr = '{we: 1'b1, addr: sp, data: pra_pkg::NULL_LINK};
        st_req.free_wr = '{we: 1'b1, addr: sp, data: 1'b1};
      end
      S_F3: begin
        if (old < pra_pkg::NULL_LINK)
          st_req.prev_wr = '{we: 1'b1, addr: old[IW-1:0], data: TW'(sp)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      ret     <= S_DONE;
      clr     <= '0;
      st      <= pra_pkg::ST_DONE;
      granted <= '0;
      for (int i = 0; i < NO; i++) heads[i] <= pra_pkg::NULL_LINK;
      // The whole window starts as one free run on the list of its own order.
      heads[pra_pkg::size_order(pra_pkg::NULL_LINK)] <= '0;
    end else begin
      case (state)
        S_CLR: begin
          clr <= clr + 1'b1;
          if (clr == TW'(W - 1)) state <= S_INIT0;
        end
        S_INIT0: state <= S_INIT1;
        S_INIT1: state <= S_IDLE;
        S_IDLE: begin
          if (start) begin
            granted <= '0;
            st      <= pra_pkg::ST_DONE;
            if (!operation) begin
              cnt <= page_count;
              if (page_count == '0 || page_count > TW'(W)) begin
                st    <= pra_pkg::ST_BADCNT;
                state <= S_DONE;
              end else begin
                o     <= pra_pkg::size_order(page_count);
                state <= S_A1;
              end
            end else begin
              sp    <= run_start;
              state <= S_FR1;
            end
          end
        end
        S_A1: begin
          if (heads[o] < pra_pkg::NULL_LINK) begin
            p     <= heads[o][IW-1:0];
            steps <= '0;
            state <= S_A2;
          end else begin
            state <= S_ANEXT;
          end
        end
        S_A2: begin
          if (alu_rsp.ge) begin
            found <= p;
            have  <= st_rsp.tag;
            rp    <= p;
            rlen  <= st_rsp.tag;
            ret   <= S_AX0;
            state <= S_RM0;
          end else if (st_rsp.nxt < pra_pkg::NULL_LINK && steps < TW'(W - 1)) begin
            p     <= st_rsp.nxt[IW-1:0];
            steps <= steps + 1'b1;
          end else begin
            state <= S_ANEXT;
          end
        end
        S_ANEXT: begin
          if (o == pra_pkg::ORD_W'(NO - 1)) begin
            st    <= pra_pkg::ST_NOFIT;
            state <= S_DONE;
          end else begin
            o     <= o + 1'b1;
            state <= S_A1;
          end
        end
        S_RM0: state <= S_RM1;
        S_RM1: begin
          if (st_rsp.prv >= pra_pkg::NULL_LINK && heads[rm_ord] == TW'(rp))
            heads[rm_ord] <= st_rsp.nxt;
          state <= S_RM2;
        end
        S_RM2: state <= ret;
        S_AX0: begin
          last    <= alu_rsp.res[IW-1:0];
          granted <= found;
          state   <= S_AX1;
        end
        S_AX1: begin
          rem   <= alu_rsp.res[TW-1:0];
          state <= S_AX2;
        end
        S_AX2: begin
          if (rem != '0 && alu_rsp.res <= AW'(W)) state <= S_AX3;
          else state <= S_DONE;
        end
        S_AX3: begin
          sp    <= alu_rsp.res[IW-1:0];
          len   <= rem;
          state <= S_L0;
        end
        S_FR1: begin
          if (st_rsp.tag == '0 || alu_rsp.res > AW'(W)) begin
            st    <= pra_pkg::ST_BADCNT;
            state <= S_DONE;
          end else if (!st_rsp.free) begin
            len   <= st_rsp.tag;
            state <= S_L0;
          end else begin
            state <= S_DONE;
          end
        end
        S_L0: state <= (sp == '0) ? S_R0 : S_L1;
        S_L1: begin
          t <= st_rsp.tag;
          if (st_rsp.tag != '0 && alu_rsp.ge) state <= S_L1B;
          else state <= S_R0;
        end
        S_L1B: begin
          pp    <= alu_rsp.res[IW-1:0];
          state <= S_L2;
        end
        S_L2: begin
          if (st_rsp.free && st_rsp.tag == t) begin
            rp    <= pp;
            rlen  <= t;
            ret   <= S_L3;
            state <= S_RM0;
          end else begin
            state <= S_R0;
          end
        end
        S_L3: begin
          sp    <= pp;
          len   <= alu_rsp.res[TW-1:0];
          state <= S_R0;
        end
        S_R0: begin
          n <= alu_rsp.res[IW-1:0];
          if (alu_rsp.res < AW'(W)) state <= S_R1;
          else state <= S_F0;
        end
        S_R1: begin
          tn <= st_rsp.tag;
          if (st_rsp.free && st_rsp.tag != '0 && alu_rsp.res <= AW'(W)) begin
            rp    <= n;
            rlen  <= st_rsp.tag;
            ret   <= S_R2;
            state <= S_RM0;
          end else begin
            state <= S_F0;
          end
        end
        S_R2: begin
          len   <= alu_rsp.res[TW-1:0];
          state <= S_F0;
        end
        S_F0: state <= S_F1;
        S_F1: state <= S_F2;
        S_F2: begin
          old             <= heads[push_ord];
          heads[push_ord] <= TW'(sp);
          state           <= S_F3;
        end
        S_F3:   state <= S_DONE;
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/page_run_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Page run allocator
// Allocates and frees contiguous page runs with boundary tags and order lists.
// ----------------------------------------------------------------------------
// An allocation checks each order list in turn and walks its nodes, then
//   unlinks, splits and releases the rest; a free checks the tag, then merges
//   and pushes the run. Throughput: one beat at a time; busy stays high until
//   the result cycle ends. Reset: synchronous rst starts a clearing pass over
//   the page store, with busy high. Results last one cycle; the receiver
//   cannot stall.
module page_run_allocator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        operation,
  input  logic [12:0] page_count,
  input  logic [11:0] run_start,
  output logic        busy,
  output logic        done,
  output logic [1:0]  status,
  output logic [11:0] granted_start
);

  // The sequencer drives one shared adder/compare unit and one page store.
  pra_pkg::alu_req_t   alu_req;
  pra_pkg::alu_rsp_t   alu_rsp;
  pra_pkg::store_req_t st_req;
  pra_pkg::store_rsp_t st_rsp;

  pra_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .operation     (operation),
    .page_count    (page_count),
    .run_start     (run_start),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .granted_start (granted_start),
    .alu_req       (alu_req),
    .alu_rsp       (alu_rsp),
    .st_req        (st_req),
    .st_rsp        (st_rsp)
  );

  // Address and length sums, differences and compares pass through this unit.
  pra_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Tags, free marks and links share one read address per cycle.
  pra_store u_store (
    .clk (clk),
    .req (st_req),
    .rsp (st_rsp)
  );

endmodule

// ===== hdl/pra_checker.sv =====
// ----------------------------------------------------------------------------
// Page run allocator checker
// Port-level checks of the command handshake and result beats.
// ----------------------------------------------------------------------------
module pra_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [11:0] granted_start
);

  // An accepted beat keeps the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted beat did not raise busy");

  // A result beat lasts one cycle and frees the block afterwards.
  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done) else $error("result beat not followed by idle");

  // No result appears while the block is idle.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !done) else $error("result beat while idle");

  // Failed beats grant page zero and carry a status in range.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != 2'd0 |-> granted_start == '0 && status != 2'd3)
    else $error("failed beat carries a granted start");

endmodule

bind page_run_allocator_top pra_checker u_pra_checker (.*);

// ===== verif/page_run_allocator_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page run allocator testbench
// Drives allocate and free commands through the start/busy handshake and
// checks every done beat against a behavioral model of the boundary-tag
// allocator, kept in step with each accepted command.
// ----------------------------------------------------------------------------
module page_run_allocator_top_test;

  localparam int NULL_PAGE = pra_pkg::WINDOW_PAGES;
  // Idle cycles with no beat accepted on either side before the run is
  // abandoned. The clearing pass after reset and a long list walk both fit.
  localparam int STALL_LIMIT = 300000;
  // Cycles allowed after the last result for any stray beat to appear.
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    pra_pkg::status_t st;
    pra_pkg::idx_t    gs;
  } grant_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        operation;
  logic [12:0] page_count;
  logic [11:0] run_start;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [11:0] granted_start;

  page_run_allocator_top dut (
    .clk(clk), .rst(rst), .start(start), .operation(operation),
    .page_count(page_count), .run_start(run_start), .busy(busy),
    .done(done), .status(status), .granted_start(granted_start)
  );

  // Model of the allocator state: tags, free marks, links and list heads.
  int unsigned run_len [pra_pkg::WINDOW_PAGES];
  bit          is_free [pra_pkg::WINDOW_PAGES];
  int unsigned fwd     [pra_pkg::WINDOW_PAGES];
  int unsigned bwd     [pra_pkg::WINDOW_PAGES];
  int unsigned list_top[pra_pkg::SIZE_ORDERS];

  grant_t      pending_grants[$];
  int unsigned owned_heads[$];
  int          idle_pct;
  int          fail_count = 0;
  int          beats_sent = 0;
  int          beats_checked = 0;
  int          allocs_granted = 0;
  int          stall_cycles;

  // The clock runs for the whole simulation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned order_of(int unsigned len);
    int unsigned o;
    o = 0;
    while (o < 31 && (len >> (o + 1)) != 0) o++;
    if (o > pra_pkg::SIZE_ORDERS - 1) o = pra_pkg::SIZE_ORDERS - 1;
    return o;
  endfunction

  function automatic void unlink_run(int unsigned p);
    int unsigned o, pv, nx;
    o  = order_of(run_len[p]);
    pv = bwd[p];
    nx = fwd[p];
    if (pv < NULL_PAGE) fwd[pv] = nx;
    else if (list_top[o] == p) list_top[o] = nx;
    if (nx < NULL_PAGE) bwd[nx] = pv;
    fwd[p] = NULL_PAGE;
    bwd[p] = NULL_PAGE;
    is_free[p] = 1'b0;
  endfunction

  function automatic void link_run(int unsigned s);
    int unsigned o, old;
    o   = order_of(run_len[s]);
    old = list_top[o];
    fwd[s] = old;
    bwd[s] = NULL_PAGE;
    if (old < NULL_PAGE) bwd[old] = s;
    list_top[o] = s;
    is_free[s] = 1'b1;
  endfunction

  // Returns a run to the free lists, coalescing with free neighbors.
  function automatic void merge_release(int unsigned s, int unsigned len);
    int unsigned t, p, n, tn;
    if (s > 0) begin
      t = run_len[s - 1];
      if (t >= 1 && t <= s) begin
        p = s - t;
        if (is_free[p] && run_len[p] == t) begin
          unlink_run(p);
          s = p;
          len += t;
        end
      end
    end
    if (s + len < pra_pkg::WINDOW_PAGES) begin
      n  = s + len;
      tn = run_len[n];
      if (is_free[n] && tn >= 1 && n + tn <= pra_pkg::WINDOW_PAGES) begin
        unlink_run(n);
        len += tn;
      end
    end
    run_len[s] = len;
    run_len[s + len - 1] = len;
    link_run(s);
  endfunction

  function automatic void clear_pages();
    for (int i = 0; i < pra_pkg::WINDOW_PAGES; i++) begin
      run_len[i] = 0;
      is_free[i] = 1'b0;
      fwd[i] = NULL_PAGE;
      bwd[i] = NULL_PAGE;
    end
    for (int i = 0; i < pra_pkg::SIZE_ORDERS; i++) list_top[i] = NULL_PAGE;
    run_len[0] = pra_pkg::WINDOW_PAGES;
    run_len[pra_pkg::WINDOW_PAGES - 1] = pra_pkg::WINDOW_PAGES;
    link_run(0);
  endfunction

  // Applies one command to the model and returns the result it must give.
  function automatic grant_t apply_command(bit op, int unsigned cnt, int unsigned rs);
    grant_t      g;
    int unsigned found, p, steps, have, len;
    g.st = pra_pkg::ST_DONE;
    g.gs = '0;
    if (op == 1'b0) begin
      if (cnt == 0 || cnt > pra_pkg::WINDOW_PAGES) begin
        g.st = pra_pkg::ST_BADCNT;
      end else begin
        found = NULL_PAGE;
        for (int o = order_of(cnt); o < pra_pkg::SIZE_ORDERS && found == NULL_PAGE;
             o++) begin
          p = list_top[o];
          steps = 0;
          while (p < NULL_PAGE && steps < pra_pkg::WINDOW_PAGES) begin
            if (run_len[p] >= cnt) begin
              found = p;
              break;
            end
            p = fwd[p];
            steps++;
          end
        end
        if (found == NULL_PAGE) begin
          g.st = pra_pkg::ST_NOFIT;
        end else begin
          have = run_len[found];
          unlink_run(found);
          run_len[found] = cnt;
          run_len[found + cnt - 1] = cnt;
          if (have > cnt && found + have <= pra_pkg::WINDOW_PAGES)
            merge_release(found + cnt, have - cnt);
          g.gs = pra_pkg::idx_t'(found);
        end
      end
    end else begin
      len = run_len[rs];
      if (len == 0 || rs + len > pra_pkg::WINDOW_PAGES) g.st = pra_pkg::ST_BADCNT;
      else if (!is_free[rs]) merge_release(rs, len);
    end
    return g;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Sends one command beat after a random idle gap, then updates the model
  // at the edge where the beat is taken.
  task automatic send_beat(bit op, int unsigned cnt, int unsigned rs);
    int     gap;
    grant_t g;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operation  <= op;
    page_count <= 13'(cnt);
    run_start  <= 12'(rs);
    start      <= 1'b1;
    do @(posedge clk); while (busy);
    g = apply_command(op, cnt, rs);
    pending_grants.push_back(g);
    beats_sent++;
    if (op == 1'b0 && g.st == pra_pkg::ST_DONE) begin
      owned_heads.push_back(g.gs);
      allocs_granted++;
    end
    if (op == 1'b1) begin
      foreach (owned_heads[i]) begin
        if (owned_heads[i] == rs) begin
          owned_heads.delete(i);
          break;
        end
      end
    end
  endtask

  // Holds the sender off until every expected result has been seen.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result checker: the block shows each result for one cycle only.
  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (done || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (done) begin
        if (pending_grants.size() == 0) begin
          report_mismatch("unexpected result beat, status", status, -1);
        end else begin
          want = pending_grants.pop_front();
          beats_checked++;
          if (status !== want.st) report_mismatch("status", status, want.st);
          if (granted_start !== want.gs)
            report_mismatch("granted_start", granted_start, want.gs);
        end
      end
    end
  end

  // Watchdog on progress.
  always @(posedge clk) begin
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d cycles with no beat", stall_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Bad counts 0, 4097, 8191, both bad free cases and the ignored double free.
  task automatic test_bad_requests();
    send_beat(1'b0, 0, 0);
    send_beat(1'b0, pra_pkg::WINDOW_PAGES + 1, 0);
    send_beat(1'b0, 8191, 4095);
    send_beat(1'b1, 0, pra_pkg::WINDOW_PAGES - 1);
    send_beat(1'b1, 0, 7);
    send_beat(1'b1, 0, 0);
  endtask

  // Full window grant, the no-fit case, and merges on either side.
  task automatic test_fit_and_merge();
    send_beat(1'b0, pra_pkg::WINDOW_PAGES, 0);
    send_beat(1'b0, 1, 0);
    send_beat(1'b1, 0, 0);
    repeat (3) send_beat(1'b0, 1, 0);
    send_beat(1'b1, 0, 0);
    send_beat(1'b1, 0, 2);
    send_beat(1'b1, 0, 1);
    send_beat(1'b0, 2048, 0);
    send_beat(1'b0, 2048, 0);
    send_beat(1'b1, 0, 2048);
    send_beat(1'b1, 0, 0);
    send_beat(1'b0, 4095, 0);
    send_beat(1'b0, 1, 0);
    send_beat(1'b1, 0, 4095);
    send_beat(1'b1, 0, 0);
  endtask

  // Mostly well-formed traffic: small allocations, frees of held runs, and
  // a little noise made of bad counts, double frees and untagged pages.
  task automatic random_traffic(int beats);
    int unsigned sel, cnt, pick, pg;
    for (int n = 0; n < beats; n++) begin
      sel = $urandom_range(99);
      if (sel < 52 || owned_heads.size() == 0) begin
        case ($urandom_range(9))
          0:       cnt = $urandom_range(pra_pkg::WINDOW_PAGES, 1);
          1, 2:    cnt = $urandom_range(512, 1);
          default: cnt = $urandom_range(48, 1);
        endcase
        send_beat(1'b0, cnt, $urandom_range(4095));
      end else if (sel < 90) begin
        pick = $urandom_range(owned_heads.size() - 1);
        send_beat(1'b1, $urandom_range(8191), owned_heads[pick]);
      end else if (sel < 94) begin
        cnt = $urandom_range(1) ? 0 : $urandom_range(8191, pra_pkg::WINDOW_PAGES + 1);
        send_beat(1'b0, cnt, $urandom_range(4095));
      end else begin
        // A free run head is ignored; a page with no tag is rejected.
        pg = NULL_PAGE;
        for (int o = 0; o < pra_pkg::SIZE_ORDERS && pg == NULL_PAGE; o++)
          pg = list_top[o];
        if ($urandom_range(1)) begin
          for (int k = 0; k < 20; k++) begin
            pick = $urandom_range(4095);
            if (run_len[pick] == 0) begin
              pg = pick;
              break;
            end
          end
        end
        if (pg < NULL_PAGE) send_beat(1'b1, $urandom_range(8191), pg);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    operation = 1'b0;
    page_count = '0;
    run_start = '0;
    idle_pct = 0;
    clear_pages();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_bad_requests();
    test_fit_and_merge();
    drain_results();

    // Phases with no idling, heavy sender idling, and light idling.
    idle_pct = 0;
    random_traffic(180);
    drain_results();
    idle_pct = 79;
    random_traffic(170);
    idle_pct = 19;
    random_traffic(180);
    drain_results();

    $display("Sent %0d command beats, checked %0d results, %0d allocations granted.",
             beats_sent, beats_checked, allocs_granted);
    $display("Covered bad counts, no-fit, double free, and merges on both sides.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pra_pkg.sv
hdl/pra_alu.sv
hdl/pra_store.sv
hdl/pra_seq.sv
hdl/page_run_allocator_top.sv
hdl/pra_checker.sv
verif/page_run_allocator_top_test.sv
